/* rtl/assert_macros.svh */
// Assertion macros used by the RTL (seconds_to_calendar_date).
// Expects signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/stc_pkg.sv */
// Shared types, constants and helper functions for the seconds-to-date block.
// No dependencies.
package stc_pkg;

  localparam int SecW = 25;

  // Constant divisions: t/60 = (t>>2)/15, t/3600 = (t>>4)/225, t/86400 = (t>>7)/675
  localparam int MinXW = 23;
  localparam int HrXW  = 21;
  localparam int DayXW = 18;
  localparam int MinQW = 20;
  localparam int HrQW  = 14;
  localparam int DayQW = 9;

  localparam int MinDiv = 15;
  localparam int HrDiv  = 225;
  localparam int DayDiv = 675;

  // Reciprocals rounded down; estimate is low by at most one
  localparam logic [MinQW-1:0] MinRecip = MinQW'((1 << MinXW) / MinDiv);
  localparam logic [HrQW-1:0]  HrRecip  = HrQW'((1 << HrXW) / HrDiv);
  localparam logic [DayQW-1:0] DayRecip = DayQW'((1 << DayXW) / DayDiv);

  localparam int HoursPerDay = 24;
  localparam int MinsPerHour = 60;
  localparam int DaysPerYear = 365;
  localparam int MonthCount  = 12;

  localparam logic [6:0] SpaceChar = 7'h20;

  // First day of year of each month, 28-day February
  localparam logic [DayQW-1:0] MonthStart [MonthCount] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [SecW-1:0]  secs;
    logic [MinQW-1:0] min_est;
    logic [HrQW-1:0]  hr_est;
    logic [DayQW-1:0] day_est;
  } quot_t;

  typedef struct packed {
    logic [DayQW-1:0] doy;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } split_t;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
    logic [6:0] third;
  } name_t;

  typedef struct packed {
    logic [3:0] month_number;
    name_t      letters;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic       out_of_range;
  } result_t;

  // Month index 0..11 to upper-case ASCII name
  function automatic name_t month_name(input logic [3:0] idx);
    name_t n;
    unique case (idx)
      4'd0:    n = '{7'h4A, 7'h41, 7'h4E};  // JAN
      4'd1:    n = '{7'h46, 7'h45, 7'h42};  // FEB
      4'd2:    n = '{7'h4D, 7'h41, 7'h52};  // MAR
      4'd3:    n = '{7'h41, 7'h50, 7'h52};  // APR
      4'd4:    n = '{7'h4D, 7'h41, 7'h59};  // MAY
      4'd5:    n = '{7'h4A, 7'h55, 7'h4E};  // JUN
      4'd6:    n = '{7'h4A, 7'h55, 7'h4C};  // JUL
      4'd7:    n = '{7'h41, 7'h55, 7'h47};  // AUG
      4'd8:    n = '{7'h53, 7'h45, 7'h50};  // SEP
      4'd9:    n = '{7'h4F, 7'h43, 7'h54};  // OCT
      4'd10:   n = '{7'h4E, 7'h4F, 7'h56};  // NOV
      4'd11:   n = '{7'h44, 7'h45, 7'h43};  // DEC
      default: n = '{SpaceChar, SpaceChar, SpaceChar};
    endcase
    return n;
  endfunction

  // Binary 0..59 to packed BCD, tens in bits [6:4]
  function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] units;
    if (v >= 6'd50) begin
      tens = 3'd5; units = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 3'd4; units = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 3'd3; units = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 3'd2; units = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 3'd1; units = v - 6'd10;
    end else begin
      tens = 3'd0; units = v;
    end
    return {tens, units[3:0]};
  endfunction

endpackage

/* rtl/seconds_to_calendar_date.sv */
// Converts a count of seconds since midnight, January 1 of a non-leap year,
// into month number, three ASCII month letters, and day/hour/minute/second in
// packed BCD (add 0x30 to a nibble for its ASCII digit). One request enters
// per clock and one result leaves per clock through a four-register pipeline:
// input register, reciprocal-multiply quotient estimates, quotient correction
// and split, then month lookup and BCD into the output register. Each stage
// moves when the one after it is empty or moving, so back-pressure on m_axis
// stalls the pipe but accepts new requests into empty stages. Day of year 365
// and beyond sets out_of_range (m_axis_tuser), with month and day zero and the
// letters as spaces; time of day is still given.
module seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [24:0] elapsed_seconds, [31:25] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [3:0] month_number, [10:4] month_letter_first,
                                      // [17:11] month_letter_second,
                                      // [24:18] month_letter_third, [30:25] day_bcd,
                                      // [36:31] hour_bcd, [43:37] minute_bcd,
                                      // [50:44] second_bcd, [55:51] zero
  output logic        m_axis_tuser    // [0] out_of_range
);

  `include "assert_macros.svh"

  // Stage valids and advance enables
  logic v_in, v_quot, v_split, v_out;
  logic en_in, en_quot, en_split, en_out;

  logic [stc_pkg::SecW-1:0] secs;
  stc_pkg::quot_t           quot_w, quot;
  stc_pkg::split_t          split_w, split;
  stc_pkg::result_t         res_w, res;

  assign en_out   = !v_out   || m_axis_tready;
  assign en_split = !v_split || en_out;
  assign en_quot  = !v_quot  || en_split;
  assign en_in    = !v_in    || en_quot;

  assign s_axis_tready = en_in;

  stc_quot u_quot (
    .secs (secs),
    .quot (quot_w)
  );

  stc_split u_split (
    .quot  (quot),
    .split (split_w)
  );

  stc_fmt u_fmt (
    .split (split),
    .res   (res_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in    <= 1'b0;
      v_quot  <= 1'b0;
      v_split <= 1'b0;
      v_out   <= 1'b0;
    end else begin
      if (en_in)    v_in    <= s_axis_tvalid;
      if (en_quot)  v_quot  <= v_in;
      if (en_split) v_split <= v_quot;
      if (en_out)   v_out   <= v_split;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (en_in)    secs  <= s_axis_tdata[stc_pkg::SecW-1:0];
    if (en_quot)  quot  <= quot_w;
    if (en_split) split <= split_w;
    if (en_out)   res   <= res_w;
  end

  assign m_axis_tvalid = v_out;
  assign m_axis_tuser  = res.out_of_range;
  assign m_axis_tdata  = {5'b0,
                          res.second_bcd,
                          res.minute_bcd,
                          res.hour_bcd,
                          res.day_bcd,
                          res.letters.third,
                          res.letters.second,
                          res.letters.first,
                          res.month_number};

  // Out-of-range results carry blank month and day
  `ASSERT_IMPLY(a_oor_blank, v_out && res.out_of_range, (res.month_number == 4'd0) && (res.day_bcd == 6'd0) && (res.letters.first == stc_pkg::SpaceChar), "out-of-range result not blanked")

  // In-range results name a real month and a nonzero day
  `ASSERT_IMPLY(a_month_ok, v_out && !res.out_of_range, (res.month_number != 4'd0) && (res.month_number <= 4'd12) && (res.day_bcd != 6'd0), "bad month or day")

  // Hour digits stay within 00..23
  `ASSERT_IMPLY(a_hour_bcd, v_out, (res.hour_bcd[5:4] <= 2'd2) && (res.hour_bcd[3:0] <= 4'd9) && ((res.hour_bcd[5:4] != 2'd2) || (res.hour_bcd[3:0] <= 4'd3)), "hour BCD out of range")

  // Minute and second digits stay within 00..59
  `ASSERT_IMPLY(a_ms_bcd, v_out, (res.minute_bcd[6:4] <= 3'd5) && (res.minute_bcd[3:0] <= 4'd9) && (res.second_bcd[6:4] <= 3'd5) && (res.second_bcd[3:0] <= 4'd9), "minute or second BCD out of range")

endmodule

/* rtl/stc_quot.sv */
// Quotient estimates of seconds by minute, hour and day via reciprocal multiply.
// Depends on stc_pkg.
module stc_quot (
  input  logic [stc_pkg::SecW-1:0] secs,
  output stc_pkg::quot_t           quot
);

  localparam int MinPW = stc_pkg::MinXW + stc_pkg::MinQW;
  localparam int HrPW  = stc_pkg::HrXW + stc_pkg::HrQW;
  localparam int DayPW = stc_pkg::DayXW + stc_pkg::DayQW;

  logic [MinPW-1:0] min_prod;
  logic [HrPW-1:0]  hr_prod;
  logic [DayPW-1:0] day_prod;

  assign min_prod = MinPW'(secs[stc_pkg::SecW-1 -: stc_pkg::MinXW])
                  * MinPW'(stc_pkg::MinRecip);
  assign hr_prod  = HrPW'(secs[stc_pkg::SecW-1 -: stc_pkg::HrXW])
                  * HrPW'(stc_pkg::HrRecip);
  assign day_prod = DayPW'(secs[stc_pkg::SecW-1 -: stc_pkg::DayXW])
                  * DayPW'(stc_pkg::DayRecip);

  assign quot.secs    = secs;
  assign quot.min_est = min_prod[stc_pkg::MinXW +: stc_pkg::MinQW];
  assign quot.hr_est  = hr_prod[stc_pkg::HrXW +: stc_pkg::HrQW];
  assign quot.day_est = day_prod[stc_pkg::DayXW +: stc_pkg::DayQW];

endmodule

/* rtl/stc_split.sv */
// Corrects quotient estimates and splits into day of year, hour, minute, second.
// Depends on stc_pkg.
module stc_split (
  input  stc_pkg::quot_t  quot,
  output stc_pkg::split_t split
);

  logic [stc_pkg::MinXW-1:0] min_x, min_rem, min_rem_c;
  logic [stc_pkg::HrXW-1:0]  hr_x, hr_rem;
  logic [stc_pkg::DayXW-1:0] day_x, day_rem;
  logic                      min_fix, hr_fix, day_fix;
  logic [stc_pkg::MinQW-1:0] min_q, minute_full;
  logic [stc_pkg::HrQW-1:0]  hr_q, hour_full;
  logic [stc_pkg::DayQW-1:0] day_q;

  assign min_x = quot.secs[stc_pkg::SecW-1 -: stc_pkg::MinXW];
  assign hr_x  = quot.secs[stc_pkg::SecW-1 -: stc_pkg::HrXW];
  assign day_x = quot.secs[stc_pkg::SecW-1 -: stc_pkg::DayXW];

  // Remainder against the estimate; at most one divisor too large
  assign min_rem = min_x - stc_pkg::MinXW'(quot.min_est)
                 * stc_pkg::MinXW'(stc_pkg::MinDiv);
  assign hr_rem  = hr_x - stc_pkg::HrXW'(quot.hr_est)
                 * stc_pkg::HrXW'(stc_pkg::HrDiv);
  assign day_rem = day_x - stc_pkg::DayXW'(quot.day_est)
                 * stc_pkg::DayXW'(stc_pkg::DayDiv);

  assign min_fix = min_rem >= stc_pkg::MinXW'(stc_pkg::MinDiv);
  assign hr_fix  = hr_rem >= stc_pkg::HrXW'(stc_pkg::HrDiv);
  assign day_fix = day_rem >= stc_pkg::DayXW'(stc_pkg::DayDiv);

  assign min_q = quot.min_est + stc_pkg::MinQW'(min_fix);
  assign hr_q  = quot.hr_est + stc_pkg::HrQW'(hr_fix);
  assign day_q = quot.day_est + stc_pkg::DayQW'(day_fix);

  assign min_rem_c = min_fix ? (min_rem - stc_pkg::MinXW'(stc_pkg::MinDiv)) : min_rem;

  // second = 4 * ((t>>2) mod 15) + t[1:0]
  assign split.second = {min_rem_c[3:0], quot.secs[1:0]};

  assign minute_full = min_q - stc_pkg::MinQW'(hr_q) * stc_pkg::MinQW'(stc_pkg::MinsPerHour);
  assign hour_full   = hr_q - stc_pkg::HrQW'(day_q) * stc_pkg::HrQW'(stc_pkg::HoursPerDay);

  assign split.minute = minute_full[5:0];
  assign split.hour   = hour_full[4:0];
  assign split.doy    = day_q;

endmodule

/* rtl/stc_fmt.sv */
// Month lookup from day of year, month letters, and BCD formatting.
// Depends on stc_pkg.
module stc_fmt (
  input  stc_pkg::split_t  split,
  output stc_pkg::result_t res
);

  logic [3:0]                month_idx;
  logic [stc_pkg::DayQW-1:0] day_off;
  logic                      in_range;
  logic [6:0]                day_bcd_w, hour_bcd_w;

  // Last month whose first day is not after the day of year
  always_comb begin
    month_idx = '0;
    for (int i = 0; i < stc_pkg::MonthCount; i++) begin
      if (split.doy >= stc_pkg::MonthStart[i]) begin
        month_idx = 4'(i);
      end
    end
  end

  assign in_range  = split.doy < stc_pkg::DayQW'(stc_pkg::DaysPerYear);
  assign day_off   = split.doy - stc_pkg::MonthStart[month_idx] + stc_pkg::DayQW'(1);
  assign day_bcd_w = stc_pkg::bin_to_bcd(day_off[5:0]);
  assign hour_bcd_w = stc_pkg::bin_to_bcd({1'b0, split.hour});

  always_comb begin
    res.hour_bcd     = hour_bcd_w[5:0];
    res.minute_bcd   = stc_pkg::bin_to_bcd(split.minute);
    res.second_bcd   = stc_pkg::bin_to_bcd(split.second);
    res.out_of_range = !in_range;
    if (in_range) begin
      res.month_number = month_idx + 4'd1;
      res.letters      = stc_pkg::month_name(month_idx);
      res.day_bcd      = day_bcd_w[5:0];
    end else begin
      res.month_number = '0;
      res.letters      = '{stc_pkg::SpaceChar, stc_pkg::SpaceChar, stc_pkg::SpaceChar};
      res.day_bcd      = '0;
    end
  end

endmodule

/* dv/seconds_to_calendar_date_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for seconds_to_calendar_date: random and directed requests,
// with an in-bench calendar predictor and an in-order scoreboard of expected dates.
// Depends only on the RTL (stc_pkg and seconds_to_calendar_date).
module seconds_to_calendar_date_tb;

  localparam int unsigned MaxSeconds = 33554431;   // 25-bit field
  localparam int unsigned SecsPerMinute = 60;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned DaysPerYear = 365;
  localparam logic [6:0] AsciiSpace = 7'h20;
  localparam int StuckLimit = 2000;     // cycles with no handshake on either side
  localparam int LongHold = 60;         // receiver hold-off that fills the pipe
  localparam int TailCycles = 16;       // extra wait after the last result, before the final check

  // Month lengths for a non-leap year, and the name string, three letters per month
  localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned MonthFirstDay [13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
  localparam logic [287:0] MonthNames = "JANFEBMARAPRMAYJUNJULAUGSEPOCTNOVDEC";

  // Mirrors {m_axis_tuser, m_axis_tdata}, lowest field last
  typedef struct packed {
    logic       out_of_range;
    logic [4:0] pad;
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [6:0] letter_third;
    logic [6:0] letter_second;
    logic [6:0] letter_first;
    logic [3:0] month_number;
  } calendar_t;

  // Holds the dates expected from accepted requests, oldest first
  class calendar_scoreboard;
    calendar_t pending_dates[$];
    logic [24:0] pending_secs[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function logic [6:0] to_bcd(input int unsigned v);
      return 7'(((v / 10) % 10) * 16 + v % 10);
    endfunction

    function logic [6:0] month_letter(input int unsigned m, input int unsigned k);
      return MonthNames[(35 - (3 * m + k)) * 8 +: 7];
    endfunction

    // Walks the month lengths; day 365 and up leaves month zero and sets the flag
    function calendar_t predict_calendar(input logic [24:0] secs);
      calendar_t r;
      int unsigned t;
      int unsigned doy;
      t = {7'b0, secs};
      r = '0;
      r.second_bcd = to_bcd(t % SecsPerMinute);
      r.minute_bcd = to_bcd((t / SecsPerMinute) % 60);
      r.hour_bcd = 6'(to_bcd((t / SecsPerHour) % 24));
      r.out_of_range = 1'b1;
      r.letter_first = AsciiSpace;
      r.letter_second = AsciiSpace;
      r.letter_third = AsciiSpace;
      doy = t / SecsPerDay;
      for (int m = 0; m < 12; m++) begin
        if (r.month_number == 4'd0) begin
          if (doy < DaysInMonth[m]) begin
            r.month_number = 4'(m + 1);
            r.day_bcd = 6'(to_bcd(doy + 1));
            r.out_of_range = 1'b0;
            r.letter_first = month_letter(m, 0);
            r.letter_second = month_letter(m, 1);
            r.letter_third = month_letter(m, 2);
          end else begin
            doy = doy - DaysInMonth[m];
          end
        end
      end
      return r;
    endfunction

    function void note_request(input logic [24:0] secs);
      pending_dates.push_back(predict_calendar(secs));
      pending_secs.push_back(secs);
    endfunction

    function int unsigned outstanding();
      return pending_dates.size();
    endfunction

    function void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Four-state compare so unknown bits on the bus count as mismatches
    function void compare_field(input string field, input logic [24:0] secs,
                                input logic [31:0] want, input logic [31:0] got);
      if (want !== got)
        note_mismatch($sformatf("%s for %0d s: expected %0h, got %0h",
                                field, secs, want, got));
    endfunction

    function void check_result(input calendar_t got);
      calendar_t want;
      logic [24:0] secs;
      if (pending_dates.size() == 0) begin
        note_mismatch($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending_dates.pop_front();
      secs = pending_secs.pop_front();
      compare_field("month_number", secs, want.month_number, got.month_number);
      compare_field("month_letter_first", secs, want.letter_first, got.letter_first);
      compare_field("month_letter_second", secs, want.letter_second, got.letter_second);
      compare_field("month_letter_third", secs, want.letter_third, got.letter_third);
      compare_field("day_bcd", secs, want.day_bcd, got.day_bcd);
      compare_field("hour_bcd", secs, want.hour_bcd, got.hour_bcd);
      compare_field("minute_bcd", secs, want.minute_bcd, got.minute_bcd);
      compare_field("second_bcd", secs, want.second_bcd, got.second_bcd);
      compare_field("tdata padding", secs, want.pad, got.pad);
      compare_field("out_of_range", secs, want.out_of_range, got.out_of_range);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;      // [24:0] elapsed_seconds, [31:25] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;           // month, three letters, day/hour/minute/second BCD
  logic        m_axis_tuser;           // [0] out_of_range

  bit gaps_on = 1'b0;        // random idling on both sides
  bit hold_request = 1'b0;   // asks the receiver for one long hold-off
  int stuck_cycles = 0;
  calendar_scoreboard date_checker = new();

  seconds_to_calendar_date dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Minute or second value biased toward its extremes
  function automatic int unsigned edge_sixty();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 59;
      default: return $urandom_range(0, 59);
    endcase
  endfunction

  // Random timestamp: full range, month boundaries, end of year, time-of-day edges
  function automatic logic [24:0] random_seconds();
    int v;
    int unsigned day;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, MaxSeconds);
      4, 5: v = MonthFirstDay[$urandom_range(0, 12)] * SecsPerDay
                + $urandom_range(0, 2 * SecsPerDay) - SecsPerDay;
      6: v = $urandom_range(360, 388) * SecsPerDay + $urandom_range(0, SecsPerDay - 1);
      7, 8: begin
        day = $urandom_range(0, 388);
        v = day * SecsPerDay + $urandom_range(0, 23) * SecsPerHour
            + edge_sixty() * SecsPerMinute + edge_sixty();
      end
      default: v = DaysPerYear * SecsPerDay + $urandom_range(0, 20) - 10;
    endcase
    if (v < 0) v = 0;
    if (v > int'(MaxSeconds)) v = MaxSeconds;
    return 25'(v);
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after
  // acceptance; tvalid stays high so back-to-back requests need no extra edge.
  task automatic send_seconds(input logic [24:0] secs);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, secs};
    do @(posedge clk); while (!s_axis_tready);
    date_checker.note_request(secs);
    @(negedge clk);
  endtask

  // Waits out every expected result with tvalid low
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (date_checker.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result monitor: every accepted result is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      date_checker.check_result({m_axis_tuser, m_axis_tdata});
  end

  // Watchdog: a run of cycles with no handshake anywhere means a hang
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts while gaps are on, one long hold-off on request,
  // always ready otherwise. Each span assigns tready once at its first falling edge.
  initial begin : result_sink
    int span;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        span = LongHold;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        span = $urandom_range(1, 6);
      end else begin
        m_axis_tready <= 1'b1;
        span = gaps_on ? $urandom_range(1, 10) : 1;
      end
      repeat (span) @(negedge clk);
    end
  end

  initial begin : request_source
    // Month starts cover every name; the rest hit time-of-day and year-end edges
    int unsigned directed_secs[$] = '{
      0, 2678400, 5097600, 7776000, 10368000, 13046400, 15638400, 18316800,
      20995200, 23587200, 26265600, 28857600,
      59, 60, 3599, 3600, 86399, 5097599, 31535999, 31536000, 33554431, 16777215
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed edges, then random requests with idling on both sides
    foreach (directed_secs[i]) send_seconds(25'(directed_secs[i]));
    gaps_on = 1'b1;
    repeat (600) send_seconds(random_seconds());

    // Back-pressure: receiver holds off while requests keep coming, so the
    // pipe fills and s_axis_tready drops; then a pause until all results are in
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_seconds(random_seconds());
    drain_results();

    gaps_on = 1'b1;
    repeat (600) send_seconds(random_seconds());

    // Closing stretch at full rate, no idling anywhere
    gaps_on = 1'b0;
    repeat (290) send_seconds(random_seconds());
    s_axis_tvalid <= 1'b0;

    while (date_checker.outstanding() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (date_checker.outstanding() != 0)
      $display("%0d expected results never arrived", date_checker.outstanding());
    if (date_checker.mismatch_count == 0 && date_checker.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/stc_pkg.sv
rtl/stc_quot.sv
rtl/stc_split.sv
rtl/stc_fmt.sv
rtl/seconds_to_calendar_date.sv
dv/seconds_to_calendar_date_tb.sv
